### rtl/b2d_pkg.sv
// ----------------------------------------------------------------------------
// b2d_pkg - shared types and constants for the binary64 to decimal converter
// Holds the unpacked request format passed through the request queue, the
// sequencer state encoding, and the character codes used on the output.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int MANT_BITS   = 52;
    localparam int EXP_W       = 11;
    localparam int EXP_BIAS    = 1023;
    // Integer part after a rounding carry can reach 2^53, so one spare bit.
    localparam int INT_W       = MANT_BITS + 2;
    localparam int BCD_DIGITS  = 16;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int CONV_STEPS  = INT_W;
    localparam int CONV_CNT_W  = 6;
    localparam int DIGIT_POS_W = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_NULL  = 8'h00;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef struct packed {
        logic                 range_err;
        logic                 neg;
        logic [INT_W-2:0]     ipart;
        logic [MANT_BITS-1:0] frac;
    } b2d_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_FRAC,
        ST_ROUND,
        ST_CONV,
        ST_LEAD,
        ST_SIGN,
        ST_INT,
        ST_DOT,
        ST_FDIG
    } b2d_state_t;

endpackage

### rtl/b2d_if.sv
// ----------------------------------------------------------------------------
// b2d_if - channel interfaces of the binary64 to decimal converter
// The value channel carries raw binary64 words in; the character channel
// carries one ASCII character of the text out per request.
// ----------------------------------------------------------------------------
interface b2d_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] double_bits;

    modport source (output valid, output double_bits, input ready);
    modport sink   (input valid, input double_bits, output ready);
endinterface

interface b2d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;
    logic       range_error;

    modport source (output valid, output symbol, output last, output range_error,
                    input ready);
    modport sink   (input valid, input symbol, input last, input range_error,
                    output ready);
endinterface

### rtl/binary64_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary64_to_decimal_ascii - IEEE binary64 to fixed-point decimal text
// Converts raw binary64 words to ASCII text, one character per request.
// ----------------------------------------------------------------------------
// Usage:
//   value_ch carries one 64-bit binary64 word per request (valid/ready).
//   char_ch returns the text one character per request: an optional '-',
//   the integer digits without leading zeros, '.', then the fraction digits.
//   The final character of a number carries last. Values whose unbiased
//   exponent lies outside 0..52 give one null character with range_error
//   and last set.
// Timing:
//   An input stage classifies the word and places it in a two-entry queue,
//   so up to three words can be taken while one is being converted. The
//   conversion sequencer handles one word at a time: a load step, up to
//   FRACTION_DIGITS digit steps, up to FRACTION_DIGITS rounding steps,
//   54 shift-and-add-three steps for the integer part, a step to find
//   the leading digit, then one character per cycle while the receiver is
//   ready; a range fault skips to its one null character after the load.
//   The 54-step binary to BCD loop dominates.
// Reset and stalls:
//   Reset empties the queue and returns the sequencer to idle. When the
//   receiver holds ready low the current character waits in the output
//   register and the sequencer pauses at its next character; the queue
//   keeps accepting words until it and the input stage are full.
// ----------------------------------------------------------------------------
module binary64_to_decimal_ascii
    import b2d_pkg::*;
#(
    parameter int FRACTION_DIGITS = 6
)
(
    input  logic      clk,
    input  logic      rst_n,
    b2d_in_if.sink    value_ch,
    b2d_out_if.source char_ch
);

    // Classified request from the input stage into the queue.
    logic      front_valid;
    logic      front_ready;
    b2d_item_t front_item;

    // Request from the queue into the conversion sequencer.
    logic      back_valid;
    logic      back_ready;
    b2d_item_t back_item;

    b2d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_ch   (value_ch),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    b2d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    b2d_back #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .char_ch    (char_ch)
    );

endmodule

### rtl/b2d_front.sv
// ----------------------------------------------------------------------------
// b2d_front - input stage: takes a binary64 word and classifies it
// Checks the exponent range and splits the significand into an integer part
// and a left-justified 52-bit binary fraction, registered for the queue.
// ----------------------------------------------------------------------------
module b2d_front
    import b2d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    b2d_in_if.sink    value_ch,
    output logic      item_valid,
    input  logic      item_ready,
    output b2d_item_t item
);

    logic                 valid_reg;
    b2d_item_t            item_reg;
    b2d_item_t            item_next;
    logic [EXP_W-1:0]     exp_field;
    logic [EXP_W-1:0]     exp_unbiased;
    logic [5:0]           shift_e;
    logic [5:0]           shift_f;
    logic [MANT_BITS-1:0] mant;

    assign exp_field    = value_ch.double_bits[62:52];
    assign mant         = value_ch.double_bits[MANT_BITS-1:0];
    assign exp_unbiased = exp_field - EXP_W'(EXP_BIAS);
    assign shift_e      = exp_unbiased[5:0];
    assign shift_f      = 6'(MANT_BITS) - shift_e;

    always_comb
    begin
        item_next.range_err = (exp_field < EXP_W'(EXP_BIAS)) ||
                              (exp_field > EXP_W'(EXP_BIAS + MANT_BITS));
        item_next.neg       = value_ch.double_bits[63];
        item_next.ipart     = {1'b1, mant} >> shift_f;
        item_next.frac      = mant << shift_e;
    end

    assign value_ch.ready = !valid_reg || item_ready;
    assign item_valid     = valid_reg;
    assign item           = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (value_ch.ready)
        begin
            valid_reg <= value_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_ch.valid && value_ch.ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### rtl/b2d_queue.sv
// ----------------------------------------------------------------------------
// b2d_queue - short request queue between the front and back parts
// A small circular buffer of classified requests, so that either side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module b2d_queue
    import b2d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  b2d_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output b2d_item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    b2d_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/b2d_back.sv
// ----------------------------------------------------------------------------
// b2d_back - conversion sequencer and character emitter
// Produces fraction digits by repeated multiply-by-ten, rounds them, turns
// the integer part into BCD by shift-and-add-three, then sends the text.
// ----------------------------------------------------------------------------
module b2d_back
    import b2d_pkg::*;
#(
    parameter int FRACTION_DIGITS = 6
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  b2d_item_t item,
    b2d_out_if.source char_ch
);

    localparam int FD   = FRACTION_DIGITS;
    localparam int IDX_W = (FD > 1) ? $clog2(FD) : 1;
    localparam int NF_W  = $clog2(FD + 1);

    b2d_state_t             state_reg, state_next;
    logic                   neg_reg, neg_next;
    logic [MANT_BITS-1:0]   frac_reg, frac_next;
    logic [INT_W-1:0]       ipart_reg, ipart_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [3:0]             fd_reg [FD];
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [NF_W-1:0]        nf_reg, nf_next;
    logic [CONV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIGIT_POS_W-1:0] pos_reg, pos_next;
    logic                   ovalid_reg, ovalid_next;
    logic [7:0]             osym_reg, osym_next;
    logic                   olast_reg, olast_next;
    logic                   oerr_reg, oerr_next;

    logic                   fd_we;
    logic [3:0]             fd_wdata;
    logic                   slot_free;
    logic [MANT_BITS+3:0]   prod;
    logic [3:0]             digit;
    logic [MANT_BITS-1:0]   rem_next;
    logic                   last_digit;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BCD_W-1:0]       bcd_shift;
    logic [DIGIT_POS_W-1:0] lead_pos;
    logic [3:0]             int_digit;
    logic [3:0]             frac_digit;

    assign slot_free  = !ovalid_reg || char_ch.ready;
    // rem * 10 as rem * 8 + rem * 2
    assign prod       = {3'b000, frac_reg, 1'b0} + {1'b0, frac_reg, 3'b000};
    assign digit      = prod[MANT_BITS+3:MANT_BITS];
    assign rem_next   = prod[MANT_BITS-1:0];
    assign last_digit = (idx_reg == IDX_W'(FD - 1));
    assign int_digit  = bcd_reg[pos_reg*4 +: 4];
    assign frac_digit = fd_reg[idx_reg];

    always_comb
    begin
        for (int g = 0; g < BCD_DIGITS; g++)
        begin
            bcd_adj[g*4 +: 4] = (bcd_reg[g*4 +: 4] >= 4'd5) ? bcd_reg[g*4 +: 4] + 4'd3
                                                             : bcd_reg[g*4 +: 4];
        end
    end

    assign bcd_shift = {bcd_adj[BCD_W-2:0], ipart_reg[INT_W-1]};

    always_comb
    begin
        lead_pos = '0;
        for (int g = 1; g < BCD_DIGITS; g++)
        begin
            if (bcd_reg[g*4 +: 4] != 4'd0)
            begin
                lead_pos = DIGIT_POS_W'(g);
            end
        end
    end

    assign item_ready          = (state_reg == ST_IDLE);
    assign char_ch.valid       = ovalid_reg;
    assign char_ch.symbol      = osym_reg;
    assign char_ch.last        = olast_reg;
    assign char_ch.range_error = oerr_reg;

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        frac_next   = frac_reg;
        ipart_next  = ipart_reg;
        bcd_next    = bcd_reg;
        idx_next    = idx_reg;
        nf_next     = nf_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg && !char_ch.ready;
        osym_next   = osym_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        fd_we       = 1'b0;
        fd_wdata    = digit;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    neg_next   = item.neg;
                    frac_next  = item.frac;
                    ipart_next = {1'b0, item.ipart};
                    bcd_next   = '0;
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = item.range_err ? ST_ERR : ST_FRAC;
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    osym_next   = CHAR_NULL;
                    olast_next  = 1'b1;
                    oerr_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_FRAC:
            begin
                fd_we     = 1'b1;
                fd_wdata  = digit;
                frac_next = rem_next;
                if (last_digit && (rem_next > {1'b1, {(MANT_BITS-1){1'b0}}}))
                begin
                    nf_next    = NF_W'(FD);
                    state_next = ST_ROUND;
                end
                else if (last_digit || (rem_next == '0))
                begin
                    nf_next    = NF_W'(idx_reg) + NF_W'(1);
                    state_next = ST_CONV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                // Ripple the round-up carry one digit per cycle.
                fd_we = 1'b1;
                if (frac_digit == 4'd9)
                begin
                    fd_wdata = 4'd0;
                    if (idx_reg == '0)
                    begin
                        ipart_next = ipart_reg + 1'b1;
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    fd_wdata   = frac_digit + 4'd1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next   = bcd_shift;
                ipart_next = {ipart_reg[INT_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CONV_CNT_W'(CONV_STEPS - 1))
                begin
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD:
            begin
                pos_next   = lead_pos;
                state_next = neg_reg ? ST_SIGN : ST_INT;
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    osym_next   = CHAR_MINUS;
                    olast_next  = 1'b0;
                    oerr_next   = 1'b0;
                    state_next  = ST_INT;
                end
            end
            ST_INT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    osym_next   = CHAR_ZERO + {4'b0000, int_digit};
                    olast_next  = 1'b0;
                    oerr_next   = 1'b0;
                    if (pos_reg == '0)
                    begin
                        state_next = ST_DOT;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            ST_DOT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    osym_next   = CHAR_DOT;
                    olast_next  = 1'b0;
                    oerr_next   = 1'b0;
                    idx_next    = '0;
                    state_next  = ST_FDIG;
                end
            end
            ST_FDIG:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    osym_next   = CHAR_ZERO + {4'b0000, frac_digit};
                    oerr_next   = 1'b0;
                    olast_next  = ((NF_W'(idx_reg) + NF_W'(1)) == nf_reg);
                    if ((NF_W'(idx_reg) + NF_W'(1)) == nf_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        frac_reg  <= frac_next;
        ipart_reg <= ipart_next;
        bcd_reg   <= bcd_next;
        idx_reg   <= idx_next;
        nf_reg    <= nf_next;
        cnt_reg   <= cnt_next;
        pos_reg   <= pos_next;
        osym_reg  <= osym_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
        if (fd_we)
        begin
            fd_reg[idx_reg] <= fd_wdata;
        end
    end

    // A range error is always a single, final, null character.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && oerr_reg) |-> (olast_reg && (osym_reg == CHAR_NULL)))
        else $error("range error result is not a lone null character");

    // The BCD conversion never runs past its step count.
    a_conv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (cnt_reg < CONV_CNT_W'(CONV_STEPS)))
        else $error("conversion step counter overran");

    // Fraction digits are only sent from the digits actually produced.
    a_fdig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FDIG) |-> (NF_W'(idx_reg) < nf_reg))
        else $error("fraction digit index beyond digit count");

    // Taking a request always starts work on it.
    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg != ST_IDLE))
        else $error("request taken but sequencer stayed idle");

endmodule
